// ===== rtl/core/json_string_unescape_macros.svh =====
// ----------------------------------------------------------------------------
// json_string_unescape_macros
// Assertion shorthands for the string unescaper checker.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_MACROS_SVH
`define JSON_STRING_UNESCAPE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define JSU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, codes and helper functions of the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

	// input item kinds
	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;

	// error codes
	localparam logic [2:0] ERR_CTRL     = 3'd0;
	localparam logic [2:0] ERR_ESC_END  = 3'd1;
	localparam logic [2:0] ERR_BAD_HEX  = 3'd2;
	localparam logic [2:0] ERR_PAIR     = 3'd3;
	localparam logic [2:0] ERR_LONE_LOW = 3'd4;
	localparam logic [2:0] ERR_BAD_ESC  = 3'd5;
	localparam logic [2:0] ERR_UNTERM   = 3'd6;

	// characters
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CTRL_LIMIT = 8'h20;

	// upper six bits of high and low surrogates
	localparam logic [5:0] SURR_HIGH = 6'b110110;
	localparam logic [5:0] SURR_LOW  = 6'b110111;
	localparam logic [20:0] SUPP_BASE = 21'h10000;

	localparam int MAX_RES = 4;
	localparam int RCNT_W  = $clog2(MAX_RES + 1);

	typedef enum logic [2:0] {
		M_DONE,
		M_TEXT,
		M_ESC,
		M_HEX,
		M_PAIR_BS,
		M_PAIR_U,
		M_PAIR_HEX
	} mode_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       finished;
		logic       error_flag;
		logic [2:0] error_kind;
	} result_t;

	typedef struct packed {
		logic [RCNT_W-1:0]         n;
		logic [MAX_RES-1:0][7:0]   b;
	} enc_t;

	// bit 4 set marks a non-hex character
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] d;
		case (c) inside
			[8'h30:8'h39]: d = {1'b0, c[3:0]};
			[8'h61:8'h66]: d = {1'b0, c[3:0] + 4'd9};
			[8'h41:8'h46]: d = {1'b0, c[3:0] + 4'd9};
			default:       d = 5'h10;
		endcase
		return d;
	endfunction

	function automatic enc_t utf8_encode(input logic [20:0] cp);
		enc_t e;
		e = '0;
		if (cp < 21'h80) begin
			e.n    = RCNT_W'(1);
			e.b[0] = cp[7:0];
		end else if (cp < 21'h800) begin
			e.n    = RCNT_W'(2);
			e.b[0] = {3'b110, cp[10:6]};
			e.b[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h10000) begin
			e.n    = RCNT_W'(3);
			e.b[0] = {4'b1110, cp[15:12]};
			e.b[1] = {2'b10, cp[11:6]};
			e.b[2] = {2'b10, cp[5:0]};
		end else begin
			e.n    = RCNT_W'(4);
			e.b[0] = {5'b11110, cp[20:18]};
			e.b[1] = {2'b10, cp[17:12]};
			e.b[2] = {2'b10, cp[11:6]};
			e.b[3] = {2'b10, cp[5:0]};
		end
		return e;
	endfunction

endpackage

// ===== rtl/core/json_string_unescape.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape
// Unescapes a JSON string body into UTF-8 bytes, one input byte per cycle while the result buffer is free.
// ----------------------------------------------------------------------------
// An input item lands in a one-entry input register, then passes through the
// escape and UTF-8 logic into a four-entry result buffer. Plain bytes flow
// at one item per cycle while the output does not stall. An item that
// makes k results (up to four for a \u escape beyond the basic plane) holds
// the buffer while its k results are taken, and the next item waits in the input
// register until the last of those results is taken. Items that make no
// result (backslash, hex digits, start items) put nothing in the buffer.
module json_string_unescape
	import jsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic [1:0] s_tuser,   // [1:0] kind
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [5:0] m_tuser,   // [0] byte_valid, [1] finished, [2] error_flag, [5:3] error_kind
	output logic       m_tlast
);

	logic              valid_s1;
	logic [1:0]        kind_s1;
	logic [7:0]        byte_s1;

	mode_t             mode_q, mode_d;
	logic [15:0]       acc_q, acc_d;
	logic [1:0]        dcnt_q, dcnt_d;
	logic [9:0]        hs_q, hs_d;

	result_t           res_q [MAX_RES];
	logic [RCNT_W-1:0] rcnt_q;

	result_t           res_d [MAX_RES];
	logic [RCNT_W-1:0] rcnt_d;

	logic              buf_free, advance, m_take;
	logic [4:0]        dig;
	logic [15:0]       acc_nx;
	logic              err_hit, fin_hit, pass_hit, enc_go;
	logic [2:0]        err_code;
	logic [20:0]       cp;
	enc_t              enc;

	assign m_take   = m_tvalid && m_tready;
	assign buf_free = (rcnt_q == '0) || ((rcnt_q == RCNT_W'(1)) && m_tready);
	assign advance  = valid_s1 && buf_free;
	assign s_tready = !valid_s1 || buf_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	assign dig    = hex_digit(byte_s1);
	assign acc_nx = {acc_q[11:0], dig[3:0]};

	// escape decoding and state update
	always_comb begin
		mode_d   = mode_q;
		acc_d    = acc_q;
		dcnt_d   = dcnt_q;
		hs_d     = hs_q;
		err_hit  = 1'b0;
		err_code = ERR_CTRL;
		fin_hit  = 1'b0;
		pass_hit = 1'b0;
		enc_go   = 1'b0;
		cp       = '0;
		case (kind_s1)
			KIND_START: begin
				mode_d = M_TEXT;
				acc_d  = '0;
				dcnt_d = '0;
				hs_d   = '0;
			end
			KIND_END: begin
				if (mode_q != M_DONE) begin
					err_hit = 1'b1;
					case (mode_q)
						M_TEXT:  err_code = ERR_UNTERM;
						M_ESC:   err_code = ERR_ESC_END;
						M_HEX:   err_code = ERR_BAD_HEX;
						default: err_code = ERR_PAIR;
					endcase
				end
			end
			KIND_BYTE: begin
				case (mode_q)
					M_TEXT: begin
						if (byte_s1 == CH_QUOTE) begin
							fin_hit = 1'b1;
						end else if (byte_s1 < CTRL_LIMIT) begin
							err_hit  = 1'b1;
							err_code = ERR_CTRL;
						end else if (byte_s1 == CH_BSLASH) begin
							mode_d = M_ESC;
						end else begin
							pass_hit = 1'b1;
						end
					end
					M_ESC: begin
						case (byte_s1)
							CH_QUOTE, CH_BSLASH, CH_SLASH: begin
								enc_go = 1'b1;
								cp     = {13'd0, byte_s1};
							end
							CH_B: begin
								enc_go = 1'b1;
								cp     = 21'h08;
							end
							CH_F: begin
								enc_go = 1'b1;
								cp     = 21'h0C;
							end
							CH_N: begin
								enc_go = 1'b1;
								cp     = 21'h0A;
							end
							CH_R: begin
								enc_go = 1'b1;
								cp     = 21'h0D;
							end
							CH_T: begin
								enc_go = 1'b1;
								cp     = 21'h09;
							end
							CH_U: begin
								mode_d = M_HEX;
								acc_d  = '0;
								dcnt_d = '0;
							end
							default: begin
								err_hit  = 1'b1;
								err_code = ERR_BAD_ESC;
							end
						endcase
					end
					M_HEX, M_PAIR_HEX: begin
						if (dig[4]) begin
							err_hit  = 1'b1;
							err_code = (mode_q == M_HEX) ? ERR_BAD_HEX : ERR_PAIR;
						end else begin
							acc_d = acc_nx;
							if (dcnt_q != 2'd3) begin
								dcnt_d = dcnt_q + 2'd1;
							end else begin
								dcnt_d = '0;
								if (mode_q == M_PAIR_HEX) begin
									if (acc_nx[15:10] != SURR_LOW) begin
										err_hit  = 1'b1;
										err_code = ERR_PAIR;
									end else begin
										enc_go = 1'b1;
										cp     = SUPP_BASE + {1'b0, hs_q, acc_nx[9:0]};
									end
								end else if (acc_nx[15:10] == SURR_HIGH) begin
									hs_d   = acc_nx[9:0];
									mode_d = M_PAIR_BS;
								end else if (acc_nx[15:10] == SURR_LOW) begin
									err_hit  = 1'b1;
									err_code = ERR_LONE_LOW;
								end else begin
									enc_go = 1'b1;
									cp     = {5'd0, acc_nx};
								end
							end
						end
					end
					M_PAIR_BS: begin
						if (byte_s1 != CH_BSLASH) begin
							err_hit  = 1'b1;
							err_code = ERR_PAIR;
						end else begin
							mode_d = M_PAIR_U;
						end
					end
					M_PAIR_U: begin
						if (byte_s1 != CH_U) begin
							err_hit  = 1'b1;
							err_code = ERR_PAIR;
						end else begin
							mode_d = M_PAIR_HEX;
							acc_d  = '0;
							dcnt_d = '0;
						end
					end
					default: begin
						mode_d = mode_q;
					end
				endcase
			end
			default: begin
				mode_d = mode_q;
			end
		endcase
		if (err_hit || fin_hit) begin
			mode_d = M_DONE;
		end else if (enc_go) begin
			mode_d = M_TEXT;
		end
	end

	assign enc = utf8_encode(cp);

	// result set for this item
	always_comb begin
		for (int i = 0; i < MAX_RES; i++) begin
			res_d[i] = '0;
		end
		rcnt_d = '0;
		if (err_hit) begin
			rcnt_d              = RCNT_W'(1);
			res_d[0].error_flag = 1'b1;
			res_d[0].error_kind = err_code;
		end else if (fin_hit) begin
			rcnt_d            = RCNT_W'(1);
			res_d[0].finished = 1'b1;
		end else if (pass_hit) begin
			rcnt_d              = RCNT_W'(1);
			res_d[0].out_byte   = byte_s1;
			res_d[0].byte_valid = 1'b1;
		end else if (enc_go) begin
			rcnt_d = enc.n;
			for (int i = 0; i < MAX_RES; i++) begin
				res_d[i].out_byte   = enc.b[i];
				res_d[i].byte_valid = (RCNT_W'(i) < enc.n);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_DONE;
			acc_q  <= '0;
			dcnt_q <= '0;
			hs_q   <= '0;
			rcnt_q <= '0;
		end else begin
			if (advance) begin
				mode_q <= mode_d;
				acc_q  <= acc_d;
				dcnt_q <= dcnt_d;
				hs_q   <= hs_d;
				rcnt_q <= rcnt_d;
			end else if (m_take) begin
				rcnt_q <= rcnt_q - RCNT_W'(1);
			end
		end
	end

	// result buffer drains from entry zero
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < MAX_RES; i++) begin
				res_q[i] <= res_d[i];
			end
		end else if (m_take) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				res_q[i] <= res_q[i+1];
			end
		end
	end

	assign m_tvalid = (rcnt_q != '0);
	assign m_tlast  = (rcnt_q == RCNT_W'(1));
	assign m_tdata  = res_q[0].out_byte;
	assign m_tuser  = {res_q[0].error_kind, res_q[0].error_flag,
		res_q[0].finished, res_q[0].byte_valid};

endmodule

// ===== rtl/core/jsu_checker.sv =====
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks on the result stream of the string unescaper.
// ----------------------------------------------------------------------------
`include "json_string_unescape_macros.svh"

module jsu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [7:0] s_tdata,   // [7:0] in_byte
	input logic [1:0] s_tuser,   // [1:0] kind
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,   // [7:0] out_byte
	input logic [5:0] m_tuser,   // [0] byte_valid, [1] finished, [2] error_flag, [5:3] error_kind
	input logic       m_tlast
);

	// a stalled result holds
	`JSU_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

	// closing quote and errors end their item
	`JSU_ASSERT_NOW(a_term_last, m_tvalid && (m_tuser[1] || m_tuser[2]), m_tlast && !m_tuser[0] && m_tdata == 8'h00, "end or error result malformed")

	// error code only with the error flag, and in range; never error and finished together
	`JSU_ASSERT_NOW(a_err_kind, m_tvalid, (m_tuser[2] ? (m_tuser[5:3] != 3'd7) : (m_tuser[5:3] == 3'd0)) && !(m_tuser[1] && m_tuser[2]), "bad error code")

	// a result that is not last is followed by another data byte
	`JSU_ASSERT_NEXT(a_seq_cont, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tuser[0], "multi-byte sequence broken")

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (.*);

// ===== sim/json_string_unescape_tb.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_tb
// Self-checking bench for the JSON string unescaper.
// ----------------------------------------------------------------------------
// Drives string bodies into the stream input and follows each accepted
// request with a behavioral model of the unescaper. The model queues the
// UTF-8 bytes, finish marks and error codes that the block must produce.
// A monitor compares every output request with the oldest queued entry.
// Directed strings cover the edge cases: pass-through extremes, every
// escape, UTF-8 lengths, surrogate pairs and each error path. Random
// strings follow, mostly well formed with some broken ones mixed in, and
// both sides idle at random. One phase holds the output off for a long
// stretch while the input keeps offering, so the block backs up.
// ----------------------------------------------------------------------------
module json_string_unescape_tb;
	import jsu_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// kind code with no meaning, the block must ignore it
	localparam logic [1:0] KIND_NONE = 2'd3;

	localparam int RANDOM_ITEMS   = 260;
	localparam int HOLD_CYCLES    = 200;
	localparam int DRAIN_CYCLES   = 4;
	localparam int TAIL_CYCLES    = 20;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       last;
		logic       fin;
		logic       err;
		logic [2:0] code;
	} uout_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = '0;
	logic [1:0] s_tuser  = '0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [5:0] m_tuser;
	logic       m_tlast;

	// model state
	mode_t       scan_st = M_DONE;
	logic [15:0] hex_acc = '0;
	logic [1:0]  ndig    = '0;
	logic [9:0]  hi_bits = '0;

	uout_t step_res [4];
	int    step_n;
	uout_t expected_out [$];

	int items_sent    = 0;
	int results_seen  = 0;
	int fail_count    = 0;
	int idle_cycles   = 0;
	bit no_gaps       = 1'b0;
	bit hold_request  = 1'b0;

	logic [7:0] simple_esc [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};

	json_string_unescape dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// model
	// ------------------------------------------------------------------

	// bit 4 set when the byte is no hex digit
	function automatic logic [4:0] nibble_of(input logic [7:0] b);
		if (b >= "0" && b <= "9")
			return {1'b0, 4'(b - "0")};
		if (b >= "a" && b <= "f")
			return {1'b0, 4'(b - "a" + 10)};
		if (b >= "A" && b <= "F")
			return {1'b0, 4'(b - "A" + 10)};
		return 5'h10;
	endfunction

	// bit 8 set when the byte after a backslash is no single-byte escape
	function automatic logic [8:0] escape_value(input logic [7:0] b);
		case (b)
			CH_QUOTE, CH_BSLASH, CH_SLASH: return {1'b0, b};
			CH_B: return 9'h008;
			CH_F: return 9'h00C;
			CH_N: return 9'h00A;
			CH_R: return 9'h00D;
			CH_T: return 9'h009;
			default: return 9'h100;
		endcase
	endfunction

	task automatic push_result(input logic [7:0] data, input logic valid, input logic fin,
			input logic err, input logic [2:0] code);
		uout_t r;
		r.data  = data;
		r.valid = valid;
		r.last  = 1'b0;
		r.fin   = fin;
		r.err   = err;
		r.code  = code;
		step_res[step_n] = r;
		step_n++;
	endtask

	task automatic reject(input logic [2:0] code);
		scan_st = M_DONE;
		push_result(8'h00, 1'b0, 1'b0, 1'b1, code);
	endtask

	task automatic emit_codepoint(input logic [20:0] cp);
		int ncont;
		logic [7:0] lead;
		scan_st = M_TEXT;
		if (cp < 21'h80) begin
			ncont = 0;
			lead  = cp[7:0];
		end else if (cp < 21'h800) begin
			ncont = 1;
			lead  = 8'hC0 | 8'(cp >> 6);
		end else if (cp < 21'h10000) begin
			ncont = 2;
			lead  = 8'hE0 | 8'(cp >> 12);
		end else begin
			ncont = 3;
			lead  = 8'hF0 | 8'(cp >> 18);
		end
		push_result(lead, 1'b1, 1'b0, 1'b0, ERR_CTRL);
		for (int i = ncont - 1; i >= 0; i--)
			push_result(8'h80 | 8'((cp >> (6 * i)) & 21'h3F), 1'b1, 1'b0, 1'b0, ERR_CTRL);
	endtask

	task automatic predict_hex(input logic [7:0] b);
		logic [4:0] d;
		d = nibble_of(b);
		if (d[4]) begin
			reject(scan_st == M_HEX ? ERR_BAD_HEX : ERR_PAIR);
		end else begin
			hex_acc = {hex_acc[11:0], d[3:0]};
			if (ndig != 2'd3) begin
				ndig++;
			end else begin
				ndig = '0;
				if (scan_st == M_PAIR_HEX) begin
					if (hex_acc[15:10] != SURR_LOW)
						reject(ERR_PAIR);
					else
						emit_codepoint(SUPP_BASE + {hi_bits, hex_acc[9:0]});
				end else if (hex_acc[15:10] == SURR_HIGH) begin
					hi_bits = hex_acc[9:0];
					scan_st = M_PAIR_BS;
				end else if (hex_acc[15:10] == SURR_LOW) begin
					reject(ERR_LONE_LOW);
				end else begin
					emit_codepoint({5'b0, hex_acc});
				end
			end
		end
	endtask

	task automatic predict_byte(input logic [7:0] b);
		logic [8:0] e;
		case (scan_st)
			M_TEXT: begin
				if (b == CH_QUOTE) begin
					scan_st = M_DONE;
					push_result(8'h00, 1'b0, 1'b1, 1'b0, ERR_CTRL);
				end else if (b < CTRL_LIMIT) begin
					reject(ERR_CTRL);
				end else if (b == CH_BSLASH) begin
					scan_st = M_ESC;
				end else begin
					push_result(b, 1'b1, 1'b0, 1'b0, ERR_CTRL);
				end
			end
			M_ESC: begin
				e = escape_value(b);
				if (b == CH_U) begin
					scan_st = M_HEX;
					hex_acc = '0;
					ndig    = '0;
				end else if (e[8]) begin
					reject(ERR_BAD_ESC);
				end else begin
					emit_codepoint({13'b0, e[7:0]});
				end
			end
			M_HEX, M_PAIR_HEX: predict_hex(b);
			M_PAIR_BS: begin
				if (b != CH_BSLASH)
					reject(ERR_PAIR);
				else
					scan_st = M_PAIR_U;
			end
			M_PAIR_U: begin
				if (b != CH_U) begin
					reject(ERR_PAIR);
				end else begin
					scan_st = M_PAIR_HEX;
					hex_acc = '0;
					ndig    = '0;
				end
			end
			default: ;
		endcase
	endtask

	task automatic predict_request(input logic [1:0] k, input logic [7:0] b);
		step_n = 0;
		if (k == KIND_START) begin
			scan_st = M_TEXT;
			hex_acc = '0;
			ndig    = '0;
			hi_bits = '0;
		end else if (k != KIND_NONE && scan_st != M_DONE) begin
			if (k == KIND_END) begin
				case (scan_st)
					M_TEXT:  reject(ERR_UNTERM);
					M_ESC:   reject(ERR_ESC_END);
					M_HEX:   reject(ERR_BAD_HEX);
					default: reject(ERR_PAIR);
				endcase
			end else begin
				predict_byte(b);
			end
		end
		for (int i = 0; i < step_n; i++) begin
			if (i == step_n - 1)
				step_res[i].last = 1'b1;
			expected_out.push_back(step_res[i]);
		end
	endtask

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------

	task automatic report_fail(input string msg);
		$display("mismatch at result %0d: %s", results_seen, msg);
		fail_count++;
	endtask

	task automatic check_result();
		uout_t want;
		if (expected_out.size() == 0) begin
			report_fail($sformatf("unexpected result data %02h user %02h", m_tdata, m_tuser));
		end else begin
			want = expected_out.pop_front();
			if (m_tdata !== want.data)
				report_fail($sformatf("out_byte %02h want %02h", m_tdata, want.data));
			if (m_tuser[0] !== want.valid)
				report_fail($sformatf("byte_valid %b want %b", m_tuser[0], want.valid));
			if (m_tlast !== want.last)
				report_fail($sformatf("last %b want %b", m_tlast, want.last));
			if (m_tuser[1] !== want.fin)
				report_fail($sformatf("finished %b want %b", m_tuser[1], want.fin));
			if (m_tuser[2] !== want.err)
				report_fail($sformatf("error_flag %b want %b", m_tuser[2], want.err));
			if (m_tuser[5:3] !== want.code)
				report_fail($sformatf("error_kind %0d want %0d", m_tuser[5:3], want.code));
		end
		results_seen++;
	endtask

	// the model runs before the check so a request is known before its results
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			predict_request(s_tuser, s_tdata);
		if (arst_n && m_tvalid && m_tready)
			check_result();
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no request moved for %0d cycles", idle_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// output side: random ready pattern, plus a long hold on request
	initial begin
		int r;
		int n;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					m_tready <= 1'b1;
					n = $urandom_range(1, 8);
				end else if (r < 65) begin
					m_tready <= 1'b1;
					n = $urandom_range(30, 80);
				end else if (r < 85) begin
					m_tready <= 1'b0;
					n = $urandom_range(1, 2);
				end else if (r < 97) begin
					m_tready <= 1'b0;
					n = $urandom_range(3, 8);
				end else begin
					m_tready <= 1'b0;
					n = $urandom_range(20, 50);
				end
				repeat (n) @(posedge clk);
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// returns once the block has taken the request
	task automatic send_item(input logic [1:0] k, input logic [7:0] b);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= b;
		do
			@(posedge clk);
		while (!s_tready);
		items_sent++;
	endtask

	task automatic send_chars(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(KIND_BYTE, s[i]);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_out.size() != 0)
			@(posedge clk);
		// items with no result may still sit in the pipeline
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10)
			return 8'("0" + nib);
		return 8'(($urandom_range(0, 1) ? "A" : "a") + nib - 10);
	endfunction

	task automatic send_unicode(input logic [15:0] v);
		send_item(KIND_BYTE, CH_BSLASH);
		send_item(KIND_BYTE, CH_U);
		for (int i = 3; i >= 0; i--)
			send_item(KIND_BYTE, hex_char(v[i*4 +: 4]));
	endtask

	// \u, zero to three good digits, then a byte that is no hex digit
	task automatic send_bad_hex();
		logic [7:0] b;
		logic [4:0] d;
		int ngood;
		ngood = $urandom_range(0, 3);
		send_item(KIND_BYTE, CH_BSLASH);
		send_item(KIND_BYTE, CH_U);
		repeat (ngood) send_item(KIND_BYTE, hex_char(4'($urandom)));
		do begin
			b = 8'($urandom);
			d = nibble_of(b);
		end while (!d[4]);
		send_item(KIND_BYTE, b);
	endtask

	function automatic logic [15:0] random_bmp();
		logic [15:0] v;
		case ($urandom_range(0, 2))
			0: v = 16'($urandom_range(0, 16'h7F));
			1: v = 16'($urandom_range(16'h80, 16'h7FF));
			default: v = 16'($urandom);
		endcase
		// keep clear of the surrogate range
		if (v[15:11] == SURR_HIGH[5:1])
			v[15] = 1'b0;
		return v;
	endfunction

	task automatic send_broken_pair();
		logic [7:0] b;
		logic [15:0] v;
		send_unicode({SURR_HIGH, 10'($urandom)});
		case ($urandom_range(0, 3))
			0: begin
				do
					b = 8'($urandom);
				while (b == CH_BSLASH);
				send_item(KIND_BYTE, b);
			end
			1: begin
				send_item(KIND_BYTE, CH_BSLASH);
				do
					b = 8'($urandom);
				while (b == CH_U);
				send_item(KIND_BYTE, b);
			end
			2: send_bad_hex();
			default: begin
				do
					v = 16'($urandom);
				while (v[15:10] == SURR_LOW);
				send_unicode(v);
			end
		endcase
	endtask

	// an escape, or plain text, cut short by the end of input
	task automatic send_cut_escape();
		case ($urandom_range(0, 3))
			0: ;
			1: send_item(KIND_BYTE, CH_BSLASH);
			2: begin
				send_item(KIND_BYTE, CH_BSLASH);
				send_item(KIND_BYTE, CH_U);
				repeat ($urandom_range(0, 3)) send_item(KIND_BYTE, hex_char(4'($urandom)));
			end
			default: begin
				send_unicode({SURR_HIGH, 10'($urandom)});
				if ($urandom_range(0, 1)) begin
					send_item(KIND_BYTE, CH_BSLASH);
					if ($urandom_range(0, 1)) begin
						send_item(KIND_BYTE, CH_U);
						repeat ($urandom_range(0, 3))
							send_item(KIND_BYTE, hex_char(4'($urandom)));
					end
				end
			end
		endcase
		send_item(KIND_END, 8'($urandom));
	endtask

	task automatic send_token(output bit ended);
		int r;
		logic [7:0] b;
		logic [8:0] e;
		ended = 1'b0;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			do
				b = 8'($urandom_range(32, 255));
			while (b == CH_QUOTE || b == CH_BSLASH);
			send_item(KIND_BYTE, b);
		end else if (r < 58) begin
			send_item(KIND_BYTE, CH_BSLASH);
			send_item(KIND_BYTE, simple_esc[$urandom_range(0, 7)]);
		end else if (r < 72) begin
			send_unicode(random_bmp());
		end else if (r < 84) begin
			send_unicode({SURR_HIGH, 10'($urandom)});
			send_unicode({SURR_LOW, 10'($urandom)});
		end else if (r < 97) begin
			ended = 1'b1;
			if (r < 88) begin
				send_item(KIND_BYTE, 8'($urandom_range(0, 31)));
			end else if (r < 90) begin
				send_item(KIND_BYTE, CH_BSLASH);
				do begin
					b = 8'($urandom);
					e = escape_value(b);
				end while (!e[8] || b == CH_U);
				send_item(KIND_BYTE, b);
			end else if (r < 92) begin
				send_bad_hex();
			end else if (r < 94) begin
				send_unicode({SURR_LOW, 10'($urandom)});
			end else begin
				send_broken_pair();
			end
		end else if (r < 98) begin
			send_item(KIND_NONE, 8'($urandom));
		end else begin
			ended = 1'b1;
			send_cut_escape();
		end
	endtask

	task automatic send_random_string();
		int ntok;
		int r;
		bit ended;
		send_item(KIND_START, 8'($urandom));
		ntok  = $urandom_range(1, 10);
		ended = 1'b0;
		for (int i = 0; i < ntok && !ended; i++)
			send_token(ended);
		if (!ended) begin
			r = $urandom_range(0, 99);
			if (r < 85)
				send_item(KIND_BYTE, CH_QUOTE);
			else if (r < 93)
				send_item(KIND_END, 8'($urandom));
		end
		// at times a stray request after the string, which may still be open
		if ($urandom_range(0, 6) == 0)
			send_item($urandom_range(0, 1) ? KIND_BYTE : KIND_END, 8'($urandom));
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	task automatic test_plain_bytes();
		send_item(KIND_START, 8'h00);
		send_item(KIND_NONE, 8'hA5);
		send_item(KIND_BYTE, CTRL_LIMIT);
		send_item(KIND_BYTE, 8'h7F);
		send_item(KIND_BYTE, 8'h80);
		send_item(KIND_BYTE, 8'hFF);
		send_item(KIND_BYTE, CH_QUOTE);
		send_item(KIND_BYTE, 8'h41);
		send_item(KIND_END, 8'hFF);
		send_item(KIND_START, 8'hFF);
		send_item(KIND_BYTE, 8'h00);
		wait_drained();
	endtask

	task automatic test_simple_escapes();
		send_item(KIND_START, 8'h00);
		send_chars("\\\"\\\\\\/\\b\\f\\n\\r\\t\"");
		wait_drained();
	endtask

	task automatic test_unicode();
		send_item(KIND_START, 8'h00);
		send_chars("\\u0000\\u07FF\\uffFF\\uD83D\\ude00\"");
		wait_drained();
	endtask

	task automatic test_error_paths();
		send_item(KIND_START, 8'h00);
		send_chars("\\q");
		send_item(KIND_START, 8'h00);
		send_item(KIND_END, 8'h00);
		send_item(KIND_START, 8'h00);
		send_chars("\\");
		send_item(KIND_END, 8'h00);
		send_item(KIND_START, 8'h00);
		send_chars("\\u7");
		send_item(KIND_END, 8'h00);
		send_item(KIND_START, 8'h00);
		send_chars("\\u12g");
		send_item(KIND_START, 8'h00);
		send_chars("\\uDBFF");
		send_item(KIND_END, 8'h00);
		send_item(KIND_START, 8'h00);
		send_chars("\\uDFFF");
		send_item(KIND_START, 8'h00);
		send_chars("\\uD800A");
		wait_drained();
	endtask

	// output held off while input keeps offering, then input waits for the drain
	task automatic test_backpressure();
		hold_request = 1'b1;
		no_gaps      = 1'b1;
		while (hold_request)
			@(posedge clk);
		send_item(KIND_START, 8'h00);
		repeat (8) begin
			send_unicode({SURR_HIGH, 10'($urandom)});
			send_unicode({SURR_LOW, 10'($urandom)});
			send_item(KIND_BYTE, 8'($urandom_range(32, 33)));
		end
		send_item(KIND_BYTE, CH_QUOTE);
		no_gaps = 1'b0;
		wait_drained();
	endtask

	task automatic test_random_strings();
		int base;
		base = items_sent;
		while (items_sent - base < RANDOM_ITEMS) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			send_random_string();
			if ($urandom_range(0, 19) == 0)
				wait_drained();
		end
		no_gaps = 1'b0;
		wait_drained();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_bytes();
		test_simple_escapes();
		test_unicode();
		test_error_paths();
		test_backpressure();
		test_random_strings();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_out.size() != 0)
			report_fail($sformatf("%0d results never arrived", expected_out.size()));
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
